// ===== rtl/core/ico_pkg.sv =====
// ============================================================================
// ico_pkg
// Shared types, constants and tables for the icosphere midpoint subdivider.
// ============================================================================
package ico_pkg;

    // Sizing
    localparam int MAX_VERTICES = 4096;
    localparam int EDGE_SLOTS   = 4096;
    localparam int COORD_BITS   = 16;
    localparam int NEWTON_STEPS = 3;

    localparam int IDX_BITS   = 12;
    localparam int VADDR_BITS = $clog2(MAX_VERTICES);
    localparam int VCNT_BITS  = $clog2(MAX_VERTICES + 1);
    localparam int SLOT_BITS  = $clog2(EDGE_SLOTS);
    localparam int KEY_BITS   = 2 * IDX_BITS;
    localparam int FRAC       = COORD_BITS - 2;
    localparam int S_BITS     = 2 * COORD_BITS;
    localparam int STEP_BITS  = $clog2(NEWTON_STEPS + 1);
    localparam int SHIFT_BASE = 44 - FRAC;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_LEVEL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_VTX  = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VFULL = 2'd1;
    localparam logic [1:0] ST_EFULL = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]          idx_t;

    typedef struct packed {
        logic [1:0] operation;
        coord_t     raw_x;
        coord_t     raw_y;
        coord_t     raw_z;
        idx_t       corner_a;
        idx_t       corner_b;
        idx_t       corner_c;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        idx_t       vertex_index;
        coord_t     pos_x;
        coord_t     pos_y;
        coord_t     pos_z;
        idx_t       tri_first;
        idx_t       tri_second;
        idx_t       tri_third;
        logic [1:0] status;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        idx_t                mid;
    } edge_ent_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_CLR_STEP,
        DP_EDGE_SETUP,
        DP_HASH,
        DP_PROBE_START,
        DP_PROBE_RD,
        DP_PROBE_NEXT,
        DP_HIT,
        DP_VRD_LO,
        DP_VRD_HI,
        DP_MIDVEC,
        DP_MAG,
        DP_SQ_MUL,
        DP_SQ_ACC,
        DP_M_INIT,
        DP_M_SHIFT,
        DP_SEED,
        DP_NT_A,
        DP_NT_B,
        DP_NT_C,
        DP_NT_D,
        DP_FIN_MUL,
        DP_FIN_RND,
        DP_ZERO_RES,
        DP_STORE_LOAD,
        DP_STORE_MID,
        DP_EMIT_VTX,
        DP_EMIT_STAT,
        DP_EMIT_TRI
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] stat;
        logic       last;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       vfull;
        logic       corner_bad;
        logic       s_zero;
        logic       m_adjust;
        logic       comp_last;
        logic       newton_last;
        logic       probe_free;
        logic       probe_hit;
        logic       probe_last;
        logic       edge_last;
        logic       edges_done;
        logic       tri_last;
        logic       clr_last;
        logic       out_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_LVL_CLR,
        S_CHECK,
        S_EDGE,
        S_HASH,
        S_PSTART,
        S_PRD,
        S_PCHK,
        S_MISS,
        S_VRD_LO,
        S_VRD_HI,
        S_MIDVEC,
        S_MAG,
        S_SQ_MUL,
        S_SQ_ACC,
        S_MINIT,
        S_MSHIFT,
        S_NT_A,
        S_NT_B,
        S_NT_C,
        S_NT_D,
        S_FIN_MUL,
        S_FIN_RND,
        S_STORE,
        S_EMIT_VTX,
        S_EMIT_STAT,
        S_EMIT_TRI
    } ctl_state_t;

    // Inverse square root seed, indexed by the top mantissa bits minus four
    function automatic logic [15:0] inv_root_seed(input logic [3:0] idx);
        logic [15:0] r;
        begin
            case (idx)
                4'd0:    r = 16'd61788;
                4'd1:    r = 16'd55889;
                4'd2:    r = 16'd51411;
                4'd3:    r = 16'd47861;
                4'd4:    r = 16'd44957;
                4'd5:    r = 16'd42525;
                4'd6:    r = 16'd40450;
                4'd7:    r = 16'd38651;
                4'd8:    r = 16'd37073;
                4'd9:    r = 16'd35673;
                4'd10:   r = 16'd34421;
                4'd11:   r = 16'd33292;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/ico_if.sv =====
// ============================================================================
// ico_if
// Valid/ready channels for input items and result words.
// ============================================================================
interface ico_in_if;
    logic               valid;
    logic               ready;
    ico_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ico_out_if;
    logic               valid;
    logic               ready;
    ico_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ico_dp.sv =====
// ============================================================================
// ico_dp
// Datapath: vertex store, edge table, shared 32x32 multiplier, inverse
// square root and normalization registers, and the result register.
// ============================================================================
module ico_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ico_pkg::ctl_cmd_t  cmd,
    output ico_pkg::dp_stat_t  st,
    input  ico_pkg::in_word_t  in_word,
    input  logic               out_ready,
    output logic               out_valid,
    output ico_pkg::out_word_t out_word
);
    import ico_pkg::*;

    localparam logic [35:0] THREE_Q30 = 36'h0C0000000;
    localparam logic [31:0] M_HIGH    = 32'h40000000;
    localparam logic [31:0] M_LOW     = 32'h10000000;
    localparam logic [63:0] MAXV      = 64'((1 << (COORD_BITS - 1)) - 1);

    // Control registers
    logic [VCNT_BITS-1:0]  vcount_reg;
    logic [1:0]            c_reg;
    logic [1:0]            k_reg;
    logic [1:0]            tri_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [SLOT_BITS-1:0]  probe_reg;
    logic [SLOT_BITS-1:0]  clr_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Payload registers
    logic [1:0]            op_reg;
    idx_t                  cr_reg [3];
    coord_t                vec_reg [3];
    logic [COORD_BITS-1:0] mag_reg [3];
    logic                  neg_reg [3];
    coord_t                res_reg [3];
    idx_t                  mid_reg [3];
    logic [S_BITS-1:0]     s_reg;
    logic [31:0]           m_reg;
    logic signed [5:0]     j_reg;
    logic [31:0]           y_reg;
    logic [63:0]           prod_reg;
    idx_t                  lo_reg;
    idx_t                  hi_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    idx_t                  new_idx_reg;
    out_word_t             out_word_reg;
    out_word_t             out_word_next;

    // Memories
    logic [3*COORD_BITS-1:0] vmem [MAX_VERTICES];
    logic [3*COORD_BITS-1:0] vrd_reg;
    logic [3*COORD_BITS-1:0] va_reg;
    edge_ent_t               emem [EDGE_SLOTS];
    edge_ent_t               erd_reg;

    // Edge endpoints for the current edge
    logic [1:0] k_nxt;
    idx_t       p_idx;
    idx_t       q_idx;
    idx_t       lo_w;
    idx_t       hi_w;

    assign k_nxt = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
    assign p_idx = cr_reg[k_reg];
    assign q_idx = cr_reg[k_nxt];
    assign lo_w  = (p_idx < q_idx) ? p_idx : q_idx;
    assign hi_w  = (p_idx < q_idx) ? q_idx : p_idx;

    // Shared multiplier operand select
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [35:0] u_w;
    logic [31:0] v_w;

    assign u_w = prod_reg[63:28];
    assign v_w = (u_w >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - u_w);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (cmd.op)
            DP_HASH:
            begin
                mul_a = 32'(key_reg);
                mul_b = HASH_MULT;
            end
            DP_SQ_MUL:
            begin
                mul_a = 32'(mag_reg[c_reg]);
                mul_b = 32'(mag_reg[c_reg]);
            end
            DP_NT_A:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            DP_NT_B:
            begin
                mul_a = m_reg;
                mul_b = prod_reg[61:30];
            end
            DP_NT_C:
            begin
                mul_a = y_reg;
                mul_b = v_w;
            end
            DP_FIN_MUL:
            begin
                mul_a = 32'(mag_reg[c_reg]);
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round, saturate and sign one normalized component
    logic [5:0]            sh_w;
    logic [63:0]           rnd_w;
    logic [COORD_BITS-1:0] sat_w;
    coord_t                comp_w;

    assign sh_w   = 6'(SHIFT_BASE) - 6'(j_reg);
    assign rnd_w  = (prod_reg + (64'd1 << (sh_w - 6'd1))) >> sh_w;
    assign sat_w  = (rnd_w > MAXV) ? MAXV[COORD_BITS-1:0] : rnd_w[COORD_BITS-1:0];
    assign comp_w = neg_reg[c_reg] ? coord_t'(-sat_w) : coord_t'(sat_w);

    // Midpoint of two stored vertices, truncated toward zero
    coord_t mid_w [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [COORD_BITS:0] sum;
            sum = $signed({va_reg[(2-i)*COORD_BITS + COORD_BITS-1],
                           va_reg[(2-i)*COORD_BITS +: COORD_BITS]})
                + $signed({vrd_reg[(2-i)*COORD_BITS + COORD_BITS-1],
                           vrd_reg[(2-i)*COORD_BITS +: COORD_BITS]});
            if (sum < 0)
            begin
                sum = sum + (COORD_BITS+1)'(1);
            end
            mid_w[i] = coord_t'(sum >>> 1);
        end
    end

    // Corner range check
    logic corner_bad_w;

    always_comb
    begin
        corner_bad_w = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (VCNT_BITS'(cr_reg[i]) >= vcount_reg)
            begin
                corner_bad_w = 1'b1;
            end
        end
    end

    // Memory ports
    logic                    vmem_we;
    logic                    vmem_re;
    idx_t                    vmem_ra;
    logic                    emem_we;
    logic                    emem_re;
    logic [SLOT_BITS-1:0]    emem_wa;
    edge_ent_t               emem_wd;

    assign vmem_we = (cmd.op == DP_STORE_LOAD) || (cmd.op == DP_STORE_MID);
    assign vmem_re = (cmd.op == DP_VRD_LO) || (cmd.op == DP_VRD_HI);
    assign vmem_ra = (cmd.op == DP_VRD_LO) ? lo_reg : hi_reg;
    assign emem_we = (cmd.op == DP_CLR_STEP) || (cmd.op == DP_STORE_MID);
    assign emem_re = (cmd.op == DP_PROBE_RD);
    assign emem_wa = (cmd.op == DP_CLR_STEP) ? clr_reg : slot_reg;
    assign emem_wd = (cmd.op == DP_CLR_STEP) ? edge_ent_t'('0)
                   : edge_ent_t'{valid: 1'b1, key: key_reg,
                                 mid: vcount_reg[IDX_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vcount_reg[VADDR_BITS-1:0]] <= {res_reg[0], res_reg[1], res_reg[2]};
        end
        if (vmem_re)
        begin
            vrd_reg <= vmem[vmem_ra[VADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emem_we)
        begin
            emem[emem_wa] <= emem_wd;
        end
        if (emem_re)
        begin
            erd_reg <= emem[slot_reg];
        end
    end

    // Result valid: set on emit, drop once the word is taken
    logic out_emit;

    assign out_emit = (cmd.op == DP_EMIT_VTX) || (cmd.op == DP_EMIT_STAT)
                   || (cmd.op == DP_EMIT_TRI);
    assign out_valid_next = out_emit || (out_valid_reg && !out_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            tri_reg       <= '0;
            step_reg      <= '0;
            probe_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (cmd.op)
                DP_LATCH:
                begin
                    k_reg   <= '0;
                    tri_reg <= '0;
                end
                DP_CLR_STEP:    clr_reg   <= clr_reg + 1'b1;
                DP_PROBE_START: probe_reg <= '0;
                DP_PROBE_NEXT:  probe_reg <= probe_reg + 1'b1;
                DP_HIT:         k_reg     <= k_reg + 2'd1;
                DP_MAG:         c_reg     <= '0;
                DP_SQ_ACC:      c_reg     <= c_reg + 2'd1;
                DP_SEED:        step_reg  <= '0;
                DP_NT_D:
                begin
                    step_reg <= step_reg + 1'b1;
                    c_reg    <= '0;
                end
                DP_FIN_RND:     c_reg      <= c_reg + 2'd1;
                DP_STORE_LOAD:  vcount_reg <= vcount_reg + 1'b1;
                DP_STORE_MID:
                begin
                    vcount_reg <= vcount_reg + 1'b1;
                    k_reg      <= k_reg + 2'd1;
                end
                DP_EMIT_TRI:    tri_reg <= tri_reg + 2'd1;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LATCH:
            begin
                op_reg     <= in_word.operation;
                cr_reg[0]  <= in_word.corner_a;
                cr_reg[1]  <= in_word.corner_b;
                cr_reg[2]  <= in_word.corner_c;
                vec_reg[0] <= in_word.raw_x;
                vec_reg[1] <= in_word.raw_y;
                vec_reg[2] <= in_word.raw_z;
            end
            DP_EDGE_SETUP:
            begin
                lo_reg  <= lo_w;
                hi_reg  <= hi_w;
                key_reg <= {lo_w, hi_w};
            end
            DP_HASH:        prod_reg <= mul_p;
            DP_PROBE_START: slot_reg <= prod_reg[16 +: SLOT_BITS];
            DP_PROBE_NEXT:  slot_reg <= slot_reg + 1'b1;
            DP_HIT:         mid_reg[k_reg] <= erd_reg.mid;
            DP_VRD_HI:      va_reg <= vrd_reg;
            DP_MIDVEC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vec_reg[i] <= mid_w[i];
                end
            end
            DP_MAG:
            begin
                s_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec_reg[i][COORD_BITS-1];
                    mag_reg[i] <= vec_reg[i][COORD_BITS-1] ? COORD_BITS'(-vec_reg[i])
                                                          : COORD_BITS'(vec_reg[i]);
                end
            end
            DP_SQ_MUL:      prod_reg <= mul_p;
            DP_SQ_ACC:      s_reg <= s_reg + prod_reg[S_BITS-1:0];
            DP_M_INIT:
            begin
                m_reg <= 32'(s_reg);
                j_reg <= '0;
            end
            DP_M_SHIFT:
            begin
                if (m_reg >= M_HIGH)
                begin
                    m_reg <= m_reg >> 2;
                    j_reg <= j_reg - 6'sd1;
                end
                else
                begin
                    m_reg <= m_reg << 2;
                    j_reg <= j_reg + 6'sd1;
                end
            end
            DP_SEED:        y_reg <= 32'(inv_root_seed(m_reg[29:26] - 4'd4)) << 14;
            DP_NT_A,
            DP_NT_B,
            DP_NT_C,
            DP_FIN_MUL:     prod_reg <= mul_p;
            DP_NT_D:        y_reg <= prod_reg[62:31];
            DP_FIN_RND:     res_reg[c_reg] <= comp_w;
            DP_ZERO_RES:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= '0;
                end
            end
            DP_STORE_LOAD:  new_idx_reg <= vcount_reg[IDX_BITS-1:0];
            DP_STORE_MID:
            begin
                new_idx_reg    <= vcount_reg[IDX_BITS-1:0];
                mid_reg[k_reg] <= vcount_reg[IDX_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Build the next result word
    always_comb
    begin
        out_word_next = '0;
        unique case (cmd.op)
            DP_EMIT_VTX:
            begin
                out_word_next.kind         = KIND_VTX;
                out_word_next.vertex_index = new_idx_reg;
                out_word_next.pos_x        = res_reg[0];
                out_word_next.pos_y        = res_reg[1];
                out_word_next.pos_z        = res_reg[2];
                out_word_next.status       = ST_OK;
                out_word_next.last         = cmd.last;
            end
            DP_EMIT_STAT:
            begin
                out_word_next.kind   = KIND_STAT;
                out_word_next.status = cmd.stat;
                out_word_next.last   = 1'b1;
            end
            DP_EMIT_TRI:
            begin
                out_word_next.kind = KIND_TRI;
                unique case (tri_reg)
                    2'd0:
                    begin
                        out_word_next.tri_first  = cr_reg[0];
                        out_word_next.tri_second = mid_reg[0];
                        out_word_next.tri_third  = mid_reg[2];
                    end
                    2'd1:
                    begin
                        out_word_next.tri_first  = cr_reg[1];
                        out_word_next.tri_second = mid_reg[1];
                        out_word_next.tri_third  = mid_reg[0];
                    end
                    2'd2:
                    begin
                        out_word_next.tri_first  = cr_reg[2];
                        out_word_next.tri_second = mid_reg[2];
                        out_word_next.tri_third  = mid_reg[1];
                    end
                    default:
                    begin
                        out_word_next.tri_first  = mid_reg[0];
                        out_word_next.tri_second = mid_reg[1];
                        out_word_next.tri_third  = mid_reg[2];
                        out_word_next.last       = 1'b1;
                    end
                endcase
            end
            default:
            begin
                out_word_next = out_word_reg;
            end
        endcase
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (out_emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // Status back to the controller
    assign st.op          = op_reg;
    assign st.vfull       = (vcount_reg >= VCNT_BITS'(MAX_VERTICES));
    assign st.corner_bad  = corner_bad_w;
    assign st.s_zero      = (s_reg == '0);
    assign st.m_adjust    = (m_reg >= M_HIGH) || (m_reg < M_LOW);
    assign st.comp_last   = (c_reg == 2'd2);
    assign st.newton_last = (step_reg == STEP_BITS'(NEWTON_STEPS - 1));
    assign st.probe_free  = !erd_reg.valid;
    assign st.probe_hit   = erd_reg.valid && (erd_reg.key == key_reg);
    assign st.probe_last  = (probe_reg == '1);
    assign st.edge_last   = (k_reg == 2'd2);
    assign st.edges_done  = (k_reg == 2'd3);
    assign st.tri_last    = (tri_reg == 2'd3);
    assign st.clr_last    = (clr_reg == '1);
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/core/ico_ctrl.sv =====
// ============================================================================
// ico_ctrl
// Controller: sequences edge probes, midpoint creation, normalization and
// result words by issuing one datapath micro-operation per cycle.
// ============================================================================
module ico_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ico_pkg::dp_stat_t st,
    output ico_pkg::ctl_cmd_t cmd
);
    import ico_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic [1:0] stat_reg;
    logic [1:0] stat_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    // Next state and micro-operation
    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        in_ready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.stat   = stat_reg;
        cmd.last   = 1'b0;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                cmd.op = DP_CLR_STEP;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (st.op == OP_LOAD)
                begin
                    if (st.vfull)
                    begin
                        stat_next  = ST_VFULL;
                        state_next = S_EMIT_STAT;
                    end
                    else
                    begin
                        state_next = S_MAG;
                    end
                end
                else if (st.op == OP_TRI)
                begin
                    state_next = S_CHECK;
                end
                else if (st.op == OP_LEVEL)
                begin
                    state_next = S_LVL_CLR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LVL_CLR:
            begin
                cmd.op = DP_CLR_STEP;
                if (st.clr_last)
                begin
                    stat_next  = ST_OK;
                    state_next = S_EMIT_STAT;
                end
            end
            S_CHECK:
            begin
                if (st.corner_bad)
                begin
                    stat_next  = ST_RANGE;
                    state_next = S_EMIT_STAT;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cmd.op     = DP_EDGE_SETUP;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                cmd.op     = DP_HASH;
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                cmd.op     = DP_PROBE_START;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.op     = DP_PROBE_RD;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                priority if (st.probe_free)
                begin
                    state_next = S_MISS;
                end
                else if (st.probe_hit)
                begin
                    cmd.op     = DP_HIT;
                    state_next = st.edge_last ? S_EMIT_TRI : S_EDGE;
                end
                else if (st.probe_last)
                begin
                    stat_next  = ST_EFULL;
                    state_next = S_EMIT_STAT;
                end
                else
                begin
                    cmd.op     = DP_PROBE_NEXT;
                    state_next = S_PRD;
                end
            end
            S_MISS:
            begin
                if (st.vfull)
                begin
                    stat_next  = ST_VFULL;
                    state_next = S_EMIT_STAT;
                end
                else
                begin
                    state_next = S_VRD_LO;
                end
            end
            S_VRD_LO:
            begin
                cmd.op     = DP_VRD_LO;
                state_next = S_VRD_HI;
            end
            S_VRD_HI:
            begin
                cmd.op     = DP_VRD_HI;
                state_next = S_MIDVEC;
            end
            S_MIDVEC:
            begin
                cmd.op     = DP_MIDVEC;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = DP_MAG;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = DP_SQ_MUL;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op     = DP_SQ_ACC;
                state_next = st.comp_last ? S_MINIT : S_SQ_MUL;
            end
            S_MINIT:
            begin
                if (st.s_zero)
                begin
                    cmd.op     = DP_ZERO_RES;
                    state_next = S_STORE;
                end
                else
                begin
                    cmd.op     = DP_M_INIT;
                    state_next = S_MSHIFT;
                end
            end
            S_MSHIFT:
            begin
                if (st.m_adjust)
                begin
                    cmd.op = DP_M_SHIFT;
                end
                else
                begin
                    cmd.op     = DP_SEED;
                    state_next = S_NT_A;
                end
            end
            S_NT_A:
            begin
                cmd.op     = DP_NT_A;
                state_next = S_NT_B;
            end
            S_NT_B:
            begin
                cmd.op     = DP_NT_B;
                state_next = S_NT_C;
            end
            S_NT_C:
            begin
                cmd.op     = DP_NT_C;
                state_next = S_NT_D;
            end
            S_NT_D:
            begin
                cmd.op     = DP_NT_D;
                state_next = st.newton_last ? S_FIN_MUL : S_NT_A;
            end
            S_FIN_MUL:
            begin
                cmd.op     = DP_FIN_MUL;
                state_next = S_FIN_RND;
            end
            S_FIN_RND:
            begin
                cmd.op     = DP_FIN_RND;
                state_next = st.comp_last ? S_STORE : S_FIN_MUL;
            end
            S_STORE:
            begin
                cmd.op     = (st.op == OP_LOAD) ? DP_STORE_LOAD : DP_STORE_MID;
                state_next = S_EMIT_VTX;
            end
            S_EMIT_VTX:
            begin
                cmd.last = (st.op == OP_LOAD);
                if (st.out_free)
                begin
                    cmd.op = DP_EMIT_VTX;
                    priority if (st.op == OP_LOAD)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (st.edges_done)
                    begin
                        state_next = S_EMIT_TRI;
                    end
                    else
                    begin
                        state_next = S_EDGE;
                    end
                end
            end
            S_EMIT_STAT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_EMIT_STAT;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_TRI:
            begin
                if (st.out_free)
                begin
                    cmd.op = DP_EMIT_TRI;
                    if (st.tri_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/icosphere_edge_midpoint_subdivider_top.sv =====
// ============================================================================
// icosphere_edge_midpoint_subdivider_top
// Icosphere midpoint subdivider: loads unit vertices, splits triangles into
// four through a hashed edge midpoint table, and clears the table per level.
// ============================================================================
//
//   Channel  Dir  Word        Handshake
//   -------  ---  ----------  --------------------------------------------
//   item     in   in_word_t   valid/ready, one op per word
//   result   out  out_word_t  valid/ready, 1..7 words per item, last marks end
//
// A load runs one normalization from accept to its result word: three
// squares, up to 14 mantissa shifts and three Newton steps on the shared
// multiplier; a zero vector skips the shifts and the Newton steps.
// A triangle probes the table once per edge, more on a collision, and
// normalizes each created midpoint; a begin-level item is almost all
// table sweep.
// After reset the edge table is swept with item.ready low.
// A waiting result word does not block the next item; a new word stalls
// the sequencer only while the result register is still full.
// ============================================================================
module icosphere_edge_midpoint_subdivider_top (
    input  logic      clk,
    input  logic      rst_n,
    ico_in_if.sink    item,
    ico_out_if.source result
);
    import ico_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t st;

    ico_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ico_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_word   (item.data),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_word  (result.data)
    );

endmodule

// ===== rtl/core/ico_check.sv =====
// ============================================================================
// ico_check
// Port-level checks for the subdivider, bound to the top level.
// ============================================================================
module ico_check (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input ico_pkg::out_word_t result_data
);
    import ico_pkg::*;

    // One item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous item in work");

    // Hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result word changed");

    // Triangles only follow successful edge work
    a_tri_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_TRI |-> result_data.status == ST_OK)
        else $error("triangle word with failure status");

    // A failure always ends the item
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_OK |-> result_data.last)
        else $error("failure word without last");

endmodule

bind icosphere_edge_midpoint_subdivider_top ico_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
